@@ hdl/dtf_pkg.sv @@
// Shared types and constants for the double to IEEE 11073 FLOAT encoder.
// Used by dtf_ctrl, dtf_datapath and the top level; no dependencies.
package dtf_pkg;

  // Magnitude bit patterns of the limits (sign bit dropped)
  localparam logic [62:0] MANT_MAX_BITS = 63'h415F_FFFF_4000_0000; // 8388605.0
  localparam logic [62:0] ONE_BITS      = 63'h3FF0_0000_0000_0000; // 1.0
  localparam logic [10:0] EXP_ONES      = 11'h7FF;
  localparam logic [10:0] EXP_BIAS_INT  = 11'd1075;  // bias plus fraction width

  localparam logic [23:0] PRECISION     = 24'd10000000;

  // Fixed FLOAT codes
  localparam logic [31:0] CODE_NAN  = 32'h007F_FFFF;
  localparam logic [31:0] CODE_PINF = 32'h007F_FFFE;
  localparam logic [31:0] CODE_NINF = 32'h0080_0002;
  localparam logic [31:0] CODE_ZERO = 32'h0000_0000;

  localparam logic signed [7:0] EXPO_TOP = 8'sd127;
  localparam logic signed [7:0] EXPO_BOT = -8'sd128;

  // Step counts of the iterative units
  localparam int DIV_STEPS = 6;   // four series steps, quotient and remainder, one fix
  localparam int GAP_STEPS = 24;  // one bit of the precision constant per cycle

  typedef enum logic [1:0] {
    WS_NAN  = 2'd0,
    WS_INF  = 2'd1,
    WS_ZERO = 2'd2,
    WS_NUM  = 2'd3
  } word_sel_e;

  typedef struct packed {
    logic      load;        // take a new item
    logic      div_start;   // load dividend, clear counter
    logic      div_step;    // one step of the divide by ten
    logic      div_fin;     // round quotient, commit, exponent up
    logic      mul_prod;    // form magnitude times ten
    logic      mul_commit;  // round product, commit, exponent down
    logic      gap_start;   // round magnitude to integer, start precision multiply
    logic      gap_step;    // one shift-add step
    logic      gap_rnd;     // round scaled value, scale rounded integer
    logic      out_load;    // capture result word
    word_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic is_nan;
    logic is_inf;
    logic is_zero;
    logic gt_max;
    logic lt_one;
    logic expo_hi;
    logic expo_lo;
    logic cand_le_max;
    logic gap_big;
    logic div_last;
    logic gap_last;
  } status_t;

endpackage

@@ hdl/dtf_datapath.sv @@
// Datapath of the FLOAT encoder: magnitude and exponent registers, the
// divide-by-ten and multiply-by-ten units and the precision check. Uses dtf_pkg.
module dtf_datapath import dtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [63:0] value_bits_i,
  output status_t     status_o,
  output logic [31:0] float_word_o
);

  logic [62:0]       mant_q;
  logic              pos_q;
  logic signed [7:0] expo_q;
  logic [5:0]        cnt_q;
  logic [58:0]       dvd_q;
  logic [58:0]       dq_q;
  logic [55:0]       quo_q;
  logic [4:0]        rem_q;
  logic [56:0]       prod_q;
  logic [10:0]       eeff_q;
  logic [76:0]       acc_q;
  logic [76:0]       mm_q;
  logic [23:0]       c_q;
  logic [23:0]       r_q;
  logic [53:0]       xm_q;
  logic [5:0]        n_q;
  logic [47:0]       r7_q;
  logic [31:0]       word_q;

  logic [10:0] fld;
  logic [51:0] frac;
  assign fld  = mant_q[62:52];
  assign frac = mant_q[51:0];

  // Divide by ten: series for 0.8 * D, then quotient D / 10 and remainder
  logic [58:0] dv_src;
  logic [58:0] dv_next;
  logic [58:0] dv_ten;
  logic [58:0] dv_rem;
  assign dv_src = {1'b1, frac, 6'd0};
  always_comb begin
    case (cnt_q)
      6'd0:    dv_next = dq_q + (dq_q >> 4);
      6'd1:    dv_next = dq_q + (dq_q >> 8);
      6'd2:    dv_next = dq_q + (dq_q >> 16);
      6'd3:    dv_next = dq_q + (dq_q >> 32);
      default: dv_next = dq_q;
    endcase
    dv_ten = {dq_q[58:3], 3'd0} + {2'd0, dq_q[58:3], 1'b0};
    dv_rem = dvd_q - dv_ten;
  end

  // Quotient rounding, nearest even
  logic        q55;
  logic [52:0] q_hi;
  logic        q_g, q_st;
  logic [53:0] q_rnd;
  logic [10:0] q_fld;
  logic [62:0] div_res;
  always_comb begin
    q55   = quo_q[55];
    q_hi  = q55 ? quo_q[55:3] : quo_q[54:2];
    q_g   = q55 ? quo_q[2] : quo_q[1];
    q_st  = q55 ? ((|quo_q[1:0]) | (|rem_q)) : (quo_q[0] | (|rem_q));
    q_rnd = {1'b0, q_hi} + 54'(q_g & (q_st | q_hi[0]));
    q_fld = fld - (q55 ? 11'd3 : 11'd4) + 11'(q_rnd[53]);
    div_res = {q_fld, (q_rnd[53] ? 52'd0 : q_rnd[51:0])};
  end

  // Times ten: operand and product
  logic [52:0] mul_m;
  logic [56:0] mul_p;
  assign mul_m = (fld == 11'd0) ? {1'b0, frac} : {1'b1, frac};
  assign mul_p = ({4'd0, mul_m} << 3) + ({4'd0, mul_m} << 1);

  // Product normalize and round, nearest even
  logic [2:0]  p_s;
  logic [56:0] p_shr;
  logic        p_g, p_st;
  logic [53:0] p_rnd;
  logic [62:0] cand;
  always_comb begin
    if (prod_q[56]) begin
      p_s = 3'd4;
    end else if (prod_q[55]) begin
      p_s = 3'd3;
    end else if (prod_q[54]) begin
      p_s = 3'd2;
    end else if (prod_q[53]) begin
      p_s = 3'd1;
    end else begin
      p_s = 3'd0;
    end
    case (p_s)
      3'd1: begin
        p_g = prod_q[0]; p_st = 1'b0;
      end
      3'd2: begin
        p_g = prod_q[1]; p_st = prod_q[0];
      end
      3'd3: begin
        p_g = prod_q[2]; p_st = |prod_q[1:0];
      end
      3'd4: begin
        p_g = prod_q[3]; p_st = |prod_q[2:0];
      end
      default: begin
        p_g = 1'b0; p_st = 1'b0;
      end
    endcase
    p_shr = prod_q >> p_s;
    p_rnd = {1'b0, p_shr[52:0]} + 54'(p_g & (p_st | p_shr[0]));
    if (p_rnd[53]) begin
      cand = {eeff_q + 11'(p_s) + 11'd1, 52'd0};
    end else if (p_rnd[52]) begin
      cand = {eeff_q + 11'(p_s), p_rnd[51:0]};
    end else begin
      cand = {11'd0, p_rnd[51:0]};
    end
  end

  // Magnitude rounded to integer, halves up
  logic [10:0] n2;
  logic [5:0]  n2s;
  logic [53:0] r_sum;
  logic [53:0] r_shr;
  always_comb begin
    n2    = EXP_BIAS_INT - fld;
    n2s   = n2[5:0];
    r_sum = {2'b01, frac} + (54'd1 << (n2s - 6'd1));
    r_shr = r_sum >> n2s;
  end

  // Scaled product rounding to a double
  logic [52:0] x_hi;
  logic        x_g, x_st;
  logic [53:0] x_rnd;
  logic [10:0] x_n;
  always_comb begin
    x_hi  = acc_q[76] ? acc_q[76:24] : acc_q[75:23];
    x_g   = acc_q[76] ? acc_q[23] : acc_q[22];
    x_st  = acc_q[76] ? (|acc_q[22:0]) : (|acc_q[21:0]);
    x_rnd = {1'b0, x_hi} + 54'(x_g & (x_st | x_hi[0]));
    x_n   = (acc_q[76] ? 11'd1051 : 11'd1052) - fld;
  end

  // Scaled value rounded to integer, halves up
  logic [53:0] s_sum;
  logic [53:0] s_int;
  assign s_sum = xm_q + (54'd1 << (n_q - 6'd1));
  assign s_int = s_sum >> n_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start || cmd_i.gap_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step || cmd_i.gap_step) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  // Hold magnitude and exponent; load on a new item, update on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mant_q <= value_bits_i[62:0];
      pos_q  <= !value_bits_i[63] && (value_bits_i[62:0] != 63'd0);
      expo_q <= '0;
    end else if (cmd_i.div_fin) begin
      mant_q <= div_res;
      expo_q <= expo_q + 8'sd1;
    end else if (cmd_i.mul_commit) begin
      mant_q <= cand;
      expo_q <= expo_q - 8'sd1;
    end
  end

  // Advance divide by ten: series, then quotient and remainder, then fix by one
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= dv_src;
      dq_q  <= {1'b0, dv_src[58:1]} + {2'd0, dv_src[58:2]};
      quo_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q <= dv_next;
      if (cnt_q == 6'd4) begin
        quo_q <= dq_q[58:3];
        rem_q <= dv_rem[4:0];
      end else if (cnt_q == 6'd5 && rem_q >= 5'd10) begin
        quo_q <= quo_q + 56'd1;
        rem_q <= rem_q - 5'd10;
      end
    end
  end

  // Capture product for the times-ten step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_prod) begin
      prod_q <= mul_p;
      eeff_q <= (fld == 11'd0) ? 11'd1 : fld;
    end
  end

  // Precision check: shift-add multiply, then round both sides
  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_start) begin
      acc_q <= '0;
      mm_q  <= {24'd0, 1'b1, frac};
      c_q   <= PRECISION;
      r_q   <= r_shr[23:0];
    end else if (cmd_i.gap_step) begin
      if (c_q[0]) begin
        acc_q <= acc_q + mm_q;
      end
      mm_q <= {mm_q[75:0], 1'b0};
      c_q  <= {1'b0, c_q[23:1]};
    end
    if (cmd_i.gap_rnd) begin
      xm_q <= x_rnd;
      n_q  <= x_n[5:0];
      r7_q <= {24'd0, r_q} * {24'd0, PRECISION};
    end
  end

  // Capture result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        WS_NAN:  word_q <= CODE_NAN;
        WS_INF:  word_q <= pos_q ? CODE_PINF : CODE_NINF;
        WS_ZERO: word_q <= CODE_ZERO;
        default: word_q <= {expo_q, (pos_q ? r_q : (24'd0 - r_q))};
      endcase
    end
  end

  assign float_word_o = word_q;

  // Status toward the controller
  always_comb begin
    status_o.is_nan      = (fld == EXP_ONES) && (frac != 52'd0);
    status_o.is_inf      = (fld == EXP_ONES) && (frac == 52'd0);
    status_o.is_zero     = (mant_q == 63'd0);
    status_o.gt_max      = (mant_q > MANT_MAX_BITS);
    status_o.lt_one      = (mant_q < ONE_BITS);
    status_o.expo_hi     = (expo_q == EXPO_TOP);
    status_o.expo_lo     = (expo_q == EXPO_BOT);
    status_o.cand_le_max = (cand <= MANT_MAX_BITS);
    status_o.gap_big     = (s_int != {6'd0, r7_q});
    status_o.div_last    = (cnt_q == 6'(DIV_STEPS - 1));
    status_o.gap_last    = (cnt_q == 6'(GAP_STEPS - 1));
  end

endmodule

@@ hdl/dtf_ctrl.sv @@
// Sequencer of the FLOAT encoder: walks the scale loops and drives the
// datapath by commands. Uses dtf_pkg.
module dtf_ctrl import dtf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHK   = 11'b000_0000_0010,
    ST_DIV   = 11'b000_0000_0100,
    ST_DIVR  = 11'b000_0000_1000,
    ST_MULAR = 11'b000_0001_0000,
    ST_GAPM  = 11'b000_0010_0000,
    ST_GAPR  = 11'b000_0100_0000,
    ST_GAPC  = 11'b000_1000_0000,
    ST_MULGR = 11'b001_0000_0000,
    ST_OUT   = 11'b010_0000_0000,
    ST_SPARE = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_sel = WS_NUM;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status_i.is_nan) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = WS_NAN;
          state_d = ST_OUT;
        end else if (status_i.is_inf) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = WS_INF;
          state_d = ST_OUT;
        end else if (status_i.is_zero) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = WS_ZERO;
          state_d = ST_OUT;
        end else if (status_i.gt_max) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else if (status_i.lt_one) begin
          cmd_o.mul_prod = 1'b1;
          state_d = ST_MULAR;
        end else begin
          cmd_o.gap_start = 1'b1;
          state_d = ST_GAPM;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (status_i.expo_hi) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = WS_INF;
          state_d = ST_OUT;
        end else begin
          cmd_o.div_fin = 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_MULAR: begin
        if (status_i.expo_lo) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = WS_ZERO;
          state_d = ST_OUT;
        end else begin
          cmd_o.mul_commit = 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_GAPM: begin
        cmd_o.gap_step = 1'b1;
        if (status_i.gap_last) begin
          state_d = ST_GAPR;
        end
      end
      ST_GAPR: begin
        cmd_o.gap_rnd = 1'b1;
        state_d = ST_GAPC;
      end
      ST_GAPC: begin
        if (status_i.gap_big && !status_i.expo_lo) begin
          cmd_o.mul_prod = 1'b1;
          state_d = ST_MULGR;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_MULGR: begin
        if (status_i.cand_le_max) begin
          cmd_o.mul_commit = 1'b1;
          state_d = ST_CHK;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Checks
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CHK))
    else $error("accepted item did not start classification");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && !in_ready_o))
    else $error("stalled result dropped");

endmodule

@@ hdl/double_to_ieee11073_float_unit.sv @@
// Top level of the double to IEEE 11073 32-bit FLOAT encoder.
// NaN, infinity and zero are coded straight from the classification; other
// values loop through divides by ten, multiplies by ten and precision checks,
// and for the largest inputs the chain of divides sets the run time.
// One item at a time: the next is taken once the result has been taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, no result.
module double_to_ieee11073_float_unit import dtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] float_word
);

  cmd_t    cmd;
  status_t status;

  dtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dtf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_bits_i (s_axis_tdata),
    .status_o     (status),
    .float_word_o (m_axis_tdata)
  );

endmodule
